// ===== design/point_to_pixel_projection_macros.svh =====
// Assertion helpers for the projection block.
`ifndef POINT_TO_PIXEL_PROJECTION_MACROS_SVH
`define POINT_TO_PIXEL_PROJECTION_MACROS_SVH

`ifndef ASSERT_OFF
`define PTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTP_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTP_ASSERT(lbl, prop, msg)
`define PTP_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ===== design/ptp_pkg.sv =====
package ptp_pkg;

  localparam int PIXEL_BITS = 13;
  localparam int SIZE_BITS  = 14;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  localparam logic [3:0] COEFF_COUNT = 4'd12;
  localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

  localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
  localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] CFG_SKEW     = 3'd2;
  localparam logic [2:0] CFG_CENTER_X = 3'd3;
  localparam logic [2:0] CFG_CENTER_Y = 3'd4;
  localparam logic [2:0] CFG_WIDTH    = 3'd5;
  localparam logic [2:0] CFG_HEIGHT   = 3'd6;

  typedef struct packed {
    logic               kind;
    logic [3:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic                  in_view;
    logic [PIXEL_BITS-1:0] pixel_col;
    logic [PIXEL_BITS-1:0] pixel_row;
    logic signed [31:0]    depth;
  } out_item_t;

  typedef struct packed {
    logic               is_pose;
    logic               idx_ok;
    logic [3:0]         idx;
    logic signed [31:0] coeff;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } q_item_t;

  typedef struct packed {
    logic signed [31:0]   focal_x;
    logic signed [31:0]   focal_y;
    logic signed [31:0]   skew;
    logic signed [31:0]   center_x;
    logic signed [31:0]   center_y;
    logic [SIZE_BITS-1:0] width;
    logic [SIZE_BITS-1:0] height;
  } cfg_regs_t;

endpackage

// ===== design/ptp_front.sv =====
module ptp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptp_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output ptp_pkg::q_item_t  q_item
);
  import ptp_pkg::*;

  q_item_t        mem_r [QDEPTH];
  q_item_t        item_nxt;
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push, pop;

  assign in_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_r];

  // classify the beat
  always_comb begin
    item_nxt.is_pose = in_data.kind;
    item_nxt.idx_ok  = (in_data.coeff_index < COEFF_COUNT);
    item_nxt.idx     = in_data.coeff_index;
    item_nxt.coeff   = in_data.coeff_value;
    item_nxt.px      = in_data.point_x;
    item_nxt.py      = in_data.point_y;
    item_nxt.pz      = in_data.point_z;
  end

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= QAW'(wr_r + 1'b1);
      if (pop)  rd_r <= QAW'(rd_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= item_nxt;
  end

endmodule

// ===== design/ptp_back.sv =====
module ptp_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ptp_pkg::cfg_regs_t cfg,
  input  logic               q_valid,
  input  ptp_pkg::q_item_t   q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ptp_pkg::out_item_t out_data
);
  import ptp_pkg::*;

  localparam int F = FRAC_BITS;
  localparam logic signed [31:0] ONE  = 32'(64'd1 << F);
  localparam logic signed [66:0] MAXV = 67'sd2147483647;
  localparam logic signed [66:0] MINV = -67'sd2147483648;

  logic en, take;

  logic signed [31:0] m_r [12];
  logic signed [31:0] pt [3];

  logic               a_v_r;
  logic signed [63:0] a_prod_nxt [9];
  logic signed [63:0] a_prod_r [9];
  logic signed [31:0] a_t_r [3];

  logic               b_v_r;
  logic signed [65:0] b_sum [3];
  logic signed [65:0] b_sh [3];
  logic signed [66:0] b_tot [3];
  logic signed [31:0] b_c_nxt [3];
  logic signed [31:0] b_c_r [3];

  logic               c_v_r;
  logic signed [32:0] c_u, c_v;
  logic signed [64:0] c_p_nxt [5];
  logic signed [64:0] c_p_r [5];
  logic signed [31:0] c_d_r;

  logic               d_v_r;
  logic signed [66:0] d_sx_r, d_sy_r;
  logic signed [31:0] d_d_r;

  logic               e_dpos;
  logic signed [66:0] e_hx, e_hy;

  logic           v_r   [F+1];
  logic           ox_r  [F+1];
  logic           oy_r  [F+1];
  logic [31:0]    dd_r  [F+1];
  logic [31:0]    rx_r  [F+1];
  logic [31:0]    ry_r  [F+1];
  logic [F-1:0]   lx_r  [F+1];
  logic [F-1:0]   ly_r  [F+1];
  logic [F-1:0]   qx_r  [F+1];
  logic [F-1:0]   qy_r  [F+1];
  logic           ox_nxt [F+1];
  logic           oy_nxt [F+1];
  logic [31:0]    rx_nxt [F+1];
  logic [31:0]    ry_nxt [F+1];
  logic [F-1:0]   lx_nxt [F+1];
  logic [F-1:0]   ly_nxt [F+1];
  logic [F-1:0]   qx_nxt [F+1];
  logic [F-1:0]   qy_nxt [F+1];

  logic [F+SIZE_BITS-1:0] prod_x, prod_y;
  logic [SIZE_BITS-1:0]   pix_x, pix_y;
  logic                   seen;
  logic                   out_valid_r;
  out_item_t              out_data_r, out_data_nxt;

  assign en    = !out_valid_r || out_ready;
  assign take  = en && q_valid;
  assign q_pop = take;

  assign pt[0] = q_item.px;
  assign pt[1] = q_item.py;
  assign pt[2] = q_item.pz;

  // world to camera products
  for (genvar g = 0; g < 9; g++) begin : g_mul
    assign a_prod_nxt[g] = m_r[(g/3)*4 + g%3] * pt[g%3];
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    assign b_sum[r] = 66'(a_prod_r[3*r]) + 66'(a_prod_r[3*r+1]) + 66'(a_prod_r[3*r+2]);
    assign b_sh[r]  = b_sum[r] >>> F;
    assign b_tot[r] = 67'(b_sh[r]) + 67'(a_t_r[r]);
    assign b_c_nxt[r] = (b_tot[r] > MAXV) ? 32'sh7FFFFFFF :
                        (b_tot[r] < MINV) ? 32'sh80000000 : b_tot[r][31:0];
  end

  // axis remap (-y, -z, x) and intrinsics
  assign c_u = -33'(b_c_r[1]);
  assign c_v = -33'(b_c_r[2]);
  assign c_p_nxt[0] = cfg.focal_x * c_u;
  assign c_p_nxt[1] = cfg.skew * c_v;
  assign c_p_nxt[2] = cfg.center_x * b_c_r[0];
  assign c_p_nxt[3] = cfg.focal_y * c_v;
  assign c_p_nxt[4] = cfg.center_y * b_c_r[0];

  // range check and divider seed
  assign e_dpos    = (d_d_r > 32'sd0);
  assign e_hx      = d_sx_r >>> F;
  assign e_hy      = d_sy_r >>> F;
  assign ox_nxt[0] = e_dpos && !d_sx_r[66] && (e_hx < 67'(d_d_r));
  assign oy_nxt[0] = e_dpos && !d_sy_r[66] && (e_hy < 67'(d_d_r));
  assign rx_nxt[0] = e_hx[31:0];
  assign ry_nxt[0] = e_hy[31:0];
  assign lx_nxt[0] = d_sx_r[F-1:0];
  assign ly_nxt[0] = d_sy_r[F-1:0];
  assign qx_nxt[0] = '0;
  assign qy_nxt[0] = '0;

  // one quotient bit per stage
  for (genvar k = 0; k < F; k++) begin : g_div
    logic [32:0] tx, ty;
    logic        bx, by;
    assign tx = {rx_r[k], lx_r[k][F-1]};
    assign ty = {ry_r[k], ly_r[k][F-1]};
    assign bx = (tx >= {1'b0, dd_r[k]});
    assign by = (ty >= {1'b0, dd_r[k]});
    assign rx_nxt[k+1] = bx ? 32'(tx - {1'b0, dd_r[k]}) : tx[31:0];
    assign ry_nxt[k+1] = by ? 32'(ty - {1'b0, dd_r[k]}) : ty[31:0];
    assign lx_nxt[k+1] = {lx_r[k][F-2:0], 1'b0};
    assign ly_nxt[k+1] = {ly_r[k][F-2:0], 1'b0};
    assign qx_nxt[k+1] = {qx_r[k][F-2:0], bx};
    assign qy_nxt[k+1] = {qy_r[k][F-2:0], by};
    assign ox_nxt[k+1] = ox_r[k];
    assign oy_nxt[k+1] = oy_r[k];
  end

  // scale to pixels
  assign prod_x = (F+SIZE_BITS)'(qx_r[F]) * (F+SIZE_BITS)'(cfg.width);
  assign prod_y = (F+SIZE_BITS)'(qy_r[F]) * (F+SIZE_BITS)'(cfg.height);
  assign pix_x  = prod_x[F+SIZE_BITS-1:F];
  assign pix_y  = prod_y[F+SIZE_BITS-1:F];
  assign seen   = ox_r[F] && oy_r[F];

  always_comb begin
    out_data_nxt.in_view   = seen;
    out_data_nxt.pixel_col = '0;
    out_data_nxt.pixel_row = '0;
    out_data_nxt.depth     = $signed(dd_r[F]);
    if (seen) begin
      out_data_nxt.pixel_col = (pix_x > SIZE_BITS'(PIX_MAX)) ? PIX_MAX : pix_x[PIXEL_BITS-1:0];
      out_data_nxt.pixel_row = (pix_y > SIZE_BITS'(PIX_MAX)) ? PIX_MAX : pix_y[PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= F; i++) v_r[i] <= 1'b0;
      for (int i = 0; i < 12; i++) m_r[i] <= (i == 0 || i == 5 || i == 10) ? ONE : '0;
    end else if (en) begin
      a_v_r       <= take && !q_item.is_pose;
      b_v_r       <= a_v_r;
      c_v_r       <= b_v_r;
      d_v_r       <= c_v_r;
      v_r[0]      <= d_v_r;
      for (int i = 1; i <= F; i++) v_r[i] <= v_r[i-1];
      out_valid_r <= v_r[F];
      if (take && q_item.is_pose && q_item.idx_ok) m_r[q_item.idx] <= q_item.coeff;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) a_prod_r[i] <= a_prod_nxt[i];
      for (int r = 0; r < 3; r++) a_t_r[r] <= m_r[r*4+3];
      for (int r = 0; r < 3; r++) b_c_r[r] <= b_c_nxt[r];
      for (int i = 0; i < 5; i++) c_p_r[i] <= c_p_nxt[i];
      c_d_r  <= b_c_r[0];
      d_sx_r <= 67'(c_p_r[0]) + 67'(c_p_r[1]) + 67'(c_p_r[2]);
      d_sy_r <= 67'(c_p_r[3]) + 67'(c_p_r[4]);
      d_d_r  <= c_d_r;
      dd_r[0] <= d_d_r;
      for (int i = 1; i <= F; i++) dd_r[i] <= dd_r[i-1];
      for (int i = 0; i <= F; i++) begin
        ox_r[i] <= ox_nxt[i];
        oy_r[i] <= oy_nxt[i];
        rx_r[i] <= rx_nxt[i];
        ry_r[i] <= ry_nxt[i];
        lx_r[i] <= lx_nxt[i];
        ly_r[i] <= ly_nxt[i];
        qx_r[i] <= qx_nxt[i];
        qy_r[i] <= qy_nxt[i];
      end
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/point_to_pixel_projection.sv =====
// Throughput: one beat per cycle unless out_ready stalls the pipeline; the column and row
// divides by depth are pipelined, one quotient bit per stage, and a four-entry queue
// decouples intake from the arithmetic pipeline.
// Pose beats update the matrix in order with points and give no result.
// Reset (rst_n low, synchronous): queue and pipeline empty, default intrinsics, identity pose.
module point_to_pixel_projection #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ptp_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import ptp_pkg::*;

  `include "point_to_pixel_projection_macros.svh"

  cfg_regs_t cfg_r;
  logic      q_valid, q_pop;
  q_item_t   q_item;
  logic      out_pix_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_x  <= 32'(64'd1 << FRAC_BITS);
      cfg_r.focal_y  <= 32'(64'd1 << FRAC_BITS);
      cfg_r.skew     <= '0;
      cfg_r.center_x <= 32'(64'd1 << (FRAC_BITS - 1));
      cfg_r.center_y <= 32'(64'd1 << (FRAC_BITS - 1));
      cfg_r.width    <= SIZE_BITS'(640);
      cfg_r.height   <= SIZE_BITS'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOCAL_X:  cfg_r.focal_x  <= cfg_wdata;
        CFG_FOCAL_Y:  cfg_r.focal_y  <= cfg_wdata;
        CFG_SKEW:     cfg_r.skew     <= cfg_wdata;
        CFG_CENTER_X: cfg_r.center_x <= cfg_wdata;
        CFG_CENTER_Y: cfg_r.center_y <= cfg_wdata;
        CFG_WIDTH:    cfg_r.width    <= cfg_wdata[SIZE_BITS-1:0];
        CFG_HEIGHT:   cfg_r.height   <= cfg_wdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  ptp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  ptp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_pix_zero = (out_data.pixel_col == '0) && (out_data.pixel_row == '0);

  `PTP_ASSERT_NR(a_reset_quiet, !rst_n |=> !out_valid, "result beat right after reset")
  `PTP_ASSERT(a_view_depth, out_valid && out_data.in_view |-> out_data.depth > 0, "bad depth")
  `PTP_ASSERT(a_out_zero, out_valid && !out_data.in_view |-> out_pix_zero, "pixel out of view")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ptp_pkg::*;

  localparam int FB        = 16;
  localparam int WDOG_MAX  = 5000;
  localparam int DRAIN_CYC = 40;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;

  point_to_pixel_projection i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  longint    pose_m[12];
  longint    k_fx, k_fy, k_skew, k_cx, k_cy;
  longint    img_w, img_h;
  out_item_t pixel_q[$];
  int        n_err;
  int        idle_pct;
  int        stall_pct;
  int        quiet_cyc;
  row_t      rows[$];

  function automatic void add_row(in_item_t it, bit typed, out_item_t want);
    row_t rr;
    rr.item  = it;
    rr.typed = typed;
    rr.want  = want;
    rows.insert(rows.size(), rr);
  endfunction

  function automatic void queue_expect(out_item_t e);
    pixel_q.insert(pixel_q.size(), e);
  endfunction

  function automatic void mac(inout longint hi, inout longint lo, input longint a,
                              input longint b);
    longint p, q;
    p  = a * b;
    q  = p >>> FB;
    hi += q;
    lo += p - (q <<< FB);
  endfunction

  function automatic bit to_pixel(longint hi, longint lo, longint d, longint size,
                                  output logic [PIXEL_BITS-1:0] pix);
    longint h, l, s, n, p;
    h = hi + (lo >>> FB);
    l = lo - ((lo >>> FB) <<< FB);
    pix = '0;
    if (h < 0 || h >= d) return 1'b0;
    s = (h <<< FB) + l;
    n = s / d;
    p = (n * size) >>> FB;
    pix = (p > longint'(PIX_MAX)) ? PIX_MAX : p[PIXEL_BITS-1:0];
    return 1'b1;
  endfunction

  function automatic bit project_point(in_item_t it, output out_item_t res);
    longint pt[3], c[3], hi, lo, u, v, d, s;
    logic [PIXEL_BITS-1:0] col, row;
    bit okx, oky, seen;
    res = '0;
    if (it.kind) begin
      if (it.coeff_index < COEFF_COUNT) pose_m[it.coeff_index] = it.coeff_value;
      return 1'b0;
    end
    pt[0] = it.point_x;
    pt[1] = it.point_y;
    pt[2] = it.point_z;
    for (int r = 0; r < 3; r++) begin
      hi = 0;
      lo = 0;
      for (int k = 0; k < 3; k++) mac(hi, lo, pose_m[r*4+k], pt[k]);
      s = hi + (lo >>> FB) + pose_m[r*4+3];
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      c[r] = s;
    end
    u = -c[1];
    v = -c[2];
    d = c[0];
    seen = 1'b0;
    col = '0;
    row = '0;
    if (d > 0) begin
      hi = 0; lo = 0;
      mac(hi, lo, k_fx, u);
      mac(hi, lo, k_skew, v);
      mac(hi, lo, k_cx, d);
      okx = to_pixel(hi, lo, d, img_w, col);
      hi = 0; lo = 0;
      mac(hi, lo, k_fy, v);
      mac(hi, lo, k_cy, d);
      oky = to_pixel(hi, lo, d, img_h, row);
      seen = okx && oky;
    end
    res.in_view   = seen;
    res.pixel_col = seen ? col : '0;
    res.pixel_row = seen ? row : '0;
    res.depth     = d[31:0];
    return 1'b1;
  endfunction

  task automatic send_beat(in_item_t it, bit typed, out_item_t want);
    out_item_t res;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (project_point(it, res)) queue_expect(typed ? want : res);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic cfg_apply(logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= i[2:0];
      cfg_wdata <= vals[i];
      case (i[2:0])
        CFG_FOCAL_X:  k_fx   = $signed(vals[i]);
        CFG_FOCAL_Y:  k_fy   = $signed(vals[i]);
        CFG_SKEW:     k_skew = $signed(vals[i]);
        CFG_CENTER_X: k_cx   = $signed(vals[i]);
        CFG_CENTER_Y: k_cy   = $signed(vals[i]);
        CFG_WIDTH:    img_w  = vals[i][SIZE_BITS-1:0];
        CFG_HEIGHT:   img_h  = vals[i][SIZE_BITS-1:0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t mk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it = '0;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    it.coeff_value = $urandom;
    return it;
  endfunction

  function automatic in_item_t mk_pose(logic [3:0] idx, logic [31:0] val);
    in_item_t it;
    it = '0;
    it.kind = 1'b1;
    it.coeff_index = idx;
    it.coeff_value = val;
    it.point_x = $urandom;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    longint d, base;
    int sel;
    int idx;
    sel = $urandom_range(99);
    if (sel < 10) begin
      it = {$urandom, $urandom, $urandom, $urandom, 5'($urandom)};
    end else if (sel < 20) begin
      idx = $urandom_range(11);
      base = (idx == 0 || idx == 5 || idx == 10) ? 65536 : 0;
      if (idx % 4 == 3) base = longint'($urandom_range(131072)) - 65536;
      else base += longint'($urandom_range(32768)) - 16384;
      it = mk_pose(idx[3:0], base[31:0]);
    end else begin
      d = $urandom_range(8 << 16, 1 << 12);
      base = longint'($urandom_range(32'(2 * d))) - d;
      it = mk_point(d[31:0], base[31:0], 32'h0);
      base = longint'($urandom_range(32'(2 * d))) - d;
      it.point_z = base[31:0];
    end
    return it;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cyc <= 0;
      else quiet_cyc <= quiet_cyc + 1;
      if (quiet_cyc >= WDOG_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected result beat %p", out_data);
          n_err++;
        end else begin
          e = pixel_q.pop_front();
          if (out_data.in_view !== e.in_view) begin
            $error("in_view expected %0d got %0d", e.in_view, out_data.in_view);
            n_err++;
          end
          if (out_data.pixel_col !== e.pixel_col) begin
            $error("pixel_col expected %0d got %0d", e.pixel_col, out_data.pixel_col);
            n_err++;
          end
          if (out_data.pixel_row !== e.pixel_row) begin
            $error("pixel_row expected %0d got %0d", e.pixel_row, out_data.pixel_row);
            n_err++;
          end
          if (out_data.depth !== e.depth) begin
            $error("depth expected %0d got %0d", e.depth, out_data.depth);
            n_err++;
          end
        end
      end
    end
  end

  initial begin
    logic [31:0] cv[8];
    out_item_t none;
    row_t rw;
    int pidle[4];
    int pstall[4];
    pidle  = '{0, 83, 0, 32};
    pstall = '{0, 0, 83, 32};
    none = '0;
    n_err = 0;
    quiet_cyc = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    k_fx = 65536; k_fy = 65536; k_skew = 0; k_cx = 32768; k_cy = 32768;
    img_w = 640; img_h = 480;
    for (int i = 0; i < 12; i++) pose_m[i] = 0;
    pose_m[0] = 65536; pose_m[5] = 65536; pose_m[10] = 65536;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    rw.typed = 1'b1;
    rw.item = mk_point(32'h0001_0000, 32'h0, 32'h0);
    rw.want = '{1'b1, 13'd320, 13'd240, 32'sh0001_0000};
    add_row(rw.item, rw.typed, rw.want);
    rw.item = mk_point(32'h0, 32'h0, 32'h0);
    rw.want = '0;
    add_row(rw.item, rw.typed, rw.want);
    rw.item = mk_point(32'hFFFF_0000, 32'h0, 32'h0);
    rw.want = '{1'b0, 13'd0, 13'd0, -32'sh0001_0000};
    add_row(rw.item, rw.typed, rw.want);
    rw.typed = 1'b0;
    rw.want = none;
    foreach (cv[i]) cv[i] = 0;
    add_row(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0, none);
    add_row(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000), 0, none);
    add_row(mk_point(32'h0000_0001, 32'h0, 32'h0), 0, none);
    add_row(mk_point(32'h0002_0000, 32'h0002_0000, 32'hFFFE_0000), 0, none);
    add_row(mk_point(32'h0002_0000, 32'hFFFE_0001, 32'h0001_FFFF), 0, none);
    add_row(mk_pose(4'd12, 32'h1234_5678), 0, none);
    add_row(mk_pose(4'd15, 32'hFFFF_FFFF), 0, none);
    add_row(mk_point(32'h0001_0000, 32'h0, 32'h0), 0, none);
    add_row(mk_pose(4'd0, 32'h7FFF_FFFF), 0, none);
    add_row(mk_pose(4'd3, 32'h8000_0000), 0, none);
    add_row(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, none);
    add_row(mk_pose(4'd11, 32'h7FFF_FFFF), 0, none);
    add_row(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, none);
    add_row(mk_pose(4'd0, 32'h0001_0000), 0, none);
    add_row(mk_pose(4'd3, 32'h0), 0, none);
    add_row(mk_pose(4'd11, 32'h0), 0, none);
    add_row(mk_pose(4'd7, 32'h0000_8000), 0, none);
    add_row(mk_point(32'h0001_0000, 32'h0000_4000, 32'hFFFF_C000), 0, none);
    add_row(mk_pose(4'd7, 32'h0), 0, none);
    foreach (rows[i]) send_beat(rows[i].item, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      idle_pct  = pidle[ph];
      stall_pct = pstall[ph];
      case (ph)
        0: cv = '{32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0000_8000, 32'h0000_8000,
                  32'd640, 32'd480, $urandom};
        1: cv = '{32'h0001_0000 + $urandom_range(32768) - 16384,
                  32'h0001_0000 + $urandom_range(32768) - 16384,
                  $urandom_range(8192) - 4096, 32'h0000_8000 + $urandom_range(4096) - 2048,
                  32'h0000_8000 + $urandom_range(4096) - 2048,
                  $urandom_range(8192, 1), $urandom_range(8192, 1), $urandom};
        2: cv = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_C000, $urandom};
        default: cv = '{32'h0000_C000, 32'h0001_4000, $urandom_range(4096) - 2048,
                        32'h0000_8000, 32'h0000_8000, 32'd8192, 32'd1, $urandom};
      endcase
      cfg_apply(cv);
      for (int n = 0; n < 310; n++) begin
        if (ph == 1 && n == 150) wait_idle();
        send_beat(rand_item(), 1'b0, none);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_err == 0 && pixel_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
